>>> src/qjet_pkg.sv
`timescale 1ns / 1ps

package qjet_pkg;

  // fixed field widths
  localparam int unsigned DataW    = 32;
  localparam int unsigned ProdW    = 64;
  localparam int unsigned IterW    = 16;
  localparam int unsigned RadW     = 31;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned StepW    = 3;

  // parameter defaults
  localparam int unsigned FracBitsDef   = 24;
  localparam int unsigned CountWidthDef = 16;

  // register reset values
  localparam logic signed [DataW-1:0] ConstRealRst = -32'sd6710886;
  localparam logic signed [DataW-1:0] ConstIRst    = 32'sd10066330;
  localparam logic signed [DataW-1:0] ConstJRst    = '0;
  localparam logic signed [DataW-1:0] ConstKRst    = '0;
  localparam logic [IterW-1:0]        MaxIterRst   = 16'd5;
  localparam logic [RadW-1:0]         RadiusRst    = 31'd83886080;

  // last step of each sequencer pass
  localparam logic [StepW-1:0] MulLastStep  = 3'd7;
  localparam logic [StepW-1:0] NormLastStep = 3'd4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CONST_REAL = 3'd0,
    CFG_CONST_I    = 3'd1,
    CFG_CONST_J    = 3'd2,
    CFG_CONST_K    = 3'd3,
    CFG_MAX_ITER   = 3'd4,
    CFG_RADIUS     = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RSQ,
    ST_ITER,
    ST_MUL,
    ST_NORM,
    ST_CMP,
    ST_DONE
  } state_e;

endpackage

>>> src/qjet_mul.sv
`timescale 1ns / 1ps

module qjet_mul import qjet_pkg::*; (
  input  logic                    clk_i,
  input  logic signed [DataW-1:0] op_a_i,
  input  logic signed [DataW-1:0] op_b_i,
  output logic signed [ProdW-1:0] prod_o
);

  logic signed [ProdW-1:0] prod_q;

  // full-precision signed product, registered
  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(op_a_i) * ProdW'(op_b_i);
  end

  assign prod_o = prod_q;

endmodule

>>> src/quaternion_julia_escape_time_unit.sv
`timescale 1ns / 1ps

// quaternion julia escape-time unit: a beat on start_i (taken while busy_o is
// low) loads a starting quaternion q, which is then replaced by q*q + c up to
// max_iter times; done_o pulses for exactly one cycle with escape_count_o, the
// zero-based index of the first iteration whose squared norm exceeds the
// squared escape radius (0 if it never escapes or escapes on iteration 0).
// the receiver cannot stall: sample escape_count_o in the cycle done_o is high.
// all arithmetic runs through a single 32x32 multiplier, so the products of a
// beat are formed one after another, and an early escape ends the beat sooner
// (a component over the radius ends the iteration in its norm pass).
// busy_o is high after the accepted beat up to and including the done_o cycle.
// configuration is for the user to write via cfg_we_i / cfg_idx_i / cfg_wdata_i
// while busy_o is low only, not enforced here; unknown indexes are ignored.

module quaternion_julia_escape_time_unit import qjet_pkg::*; #(
  parameter int unsigned FRAC_BITS   = FracBitsDef,
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command channel
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic signed [DataW-1:0]   start_real_i,
  input  logic signed [DataW-1:0]   start_i_i,
  input  logic signed [DataW-1:0]   start_j_i,
  input  logic signed [DataW-1:0]   start_k_i,
  // result strobe
  output logic                      done_o,
  output logic [IterW-1:0]          escape_count_o,
  // configuration write port
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [DataW-1:0]          cfg_wdata_i
);

  // result register keeps only the bits the count field can carry
  localparam int unsigned ResW = (COUNT_WIDTH < IterW) ? COUNT_WIDTH : IterW;

  // configuration registers
  logic signed [DataW-1:0] const_real_q, const_i_q, const_j_q, const_k_q;
  logic [IterW-1:0]        max_iter_q;
  logic [RadW-1:0]         radius_q;

  // sequencer
  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [IterW-1:0] it_q, it_d;

  // datapath
  logic signed [DataW-1:0] q_q [4];
  logic signed [DataW-1:0] q_d [4];
  logic signed [ProdW-1:0] nq_q [4];
  logic signed [ProdW-1:0] nq_d [4];
  logic [ProdW-1:0]        norm_q, norm_d;
  logic [ProdW-1:0]        rad_sq_q, rad_sq_d;
  logic [ResW-1:0]         res_q, res_d;

  // shared multiplier
  logic signed [DataW-1:0] op_a, op_b;
  logic signed [ProdW-1:0] prod;

  // product floored to frac bits, and the doubled cross term
  logic signed [ProdW-1:0] prod_fl, prod_fl2;
  logic signed [ProdW-1:0] nq_sel;
  logic [ProdW-1:0]        mag_sel;
  logic                    mag_over, norm_over, iter_end;

  qjet_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  // arithmetic shift right is floor for signed values
  assign prod_fl  = prod >>> FRAC_BITS;
  assign prod_fl2 = prod >>> (FRAC_BITS - 1);

  // magnitude of the component under test in the norm pass
  assign nq_sel    = nq_q[step_q[1:0]];
  assign mag_sel   = nq_sel[ProdW-1] ? ProdW'(-nq_sel) : ProdW'(nq_sel);
  assign mag_over  = (step_q != NormLastStep) && (mag_sel > ProdW'(radius_q));
  assign norm_over = norm_q > rad_sq_q;
  assign iter_end  = it_q == max_iter_q;

  // operand select
  always_comb begin
    op_a = q_q[0];
    op_b = q_q[0];
    unique case (state_q) inside
      ST_IDLE, ST_RSQ: begin
        op_a = DataW'(radius_q);
        op_b = DataW'(radius_q);
      end
      ST_MUL: begin
        // a*a, b*b, c*c, d*d, then a*b, a*c, a*d
        case (step_q)
          3'd1:    begin op_a = q_q[1]; op_b = q_q[1]; end
          3'd2:    begin op_a = q_q[2]; op_b = q_q[2]; end
          3'd3:    begin op_a = q_q[3]; op_b = q_q[3]; end
          3'd4:    begin op_a = q_q[0]; op_b = q_q[1]; end
          3'd5:    begin op_a = q_q[0]; op_b = q_q[2]; end
          3'd6:    begin op_a = q_q[0]; op_b = q_q[3]; end
          default: begin op_a = q_q[0]; op_b = q_q[0]; end
        endcase
      end
      ST_NORM: begin
        // magnitude is within the radius when its square is used
        op_a = mag_sel[DataW-1:0];
        op_b = mag_sel[DataW-1:0];
      end
      default: begin
        op_a = q_q[0];
        op_b = q_q[0];
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_RSQ;
      ST_RSQ:  state_d = ST_ITER;
      ST_ITER: state_d = iter_end ? ST_DONE : ST_MUL;
      ST_MUL:  if (step_q == MulLastStep) state_d = ST_NORM;
      ST_NORM: begin
        if (mag_over) begin
          state_d = ST_DONE;
        end else if (step_q == NormLastStep) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP:  state_d = norm_over ? ST_DONE : ST_ITER;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    step_d   = step_q;
    it_d     = it_q;
    q_d      = q_q;
    nq_d     = nq_q;
    norm_d   = norm_q;
    rad_sq_d = rad_sq_q;
    res_d    = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          q_d[0] = start_real_i;
          q_d[1] = start_i_i;
          q_d[2] = start_j_i;
          q_d[3] = start_k_i;
          it_d   = '0;
        end
      end
      ST_RSQ: begin
        rad_sq_d = ProdW'(prod);
      end
      ST_ITER: begin
        step_d = '0;
        if (iter_end) res_d = '0;
      end
      ST_MUL: begin
        step_d = (step_q == MulLastStep) ? '0 : step_q + 3'd1;
        // fold in the product issued one step earlier
        case (step_q)
          3'd1: nq_d[0] = {{(ProdW-DataW){const_real_q[DataW-1]}}, const_real_q} + prod_fl;
          3'd2, 3'd3, 3'd4: nq_d[0] = nq_q[0] - prod_fl;
          3'd5: nq_d[1] = {{(ProdW-DataW){const_i_q[DataW-1]}}, const_i_q} + prod_fl2;
          3'd6: nq_d[2] = {{(ProdW-DataW){const_j_q[DataW-1]}}, const_j_q} + prod_fl2;
          3'd7: nq_d[3] = {{(ProdW-DataW){const_k_q[DataW-1]}}, const_k_q} + prod_fl2;
          default: ;
        endcase
      end
      ST_NORM: begin
        step_d = step_q + 3'd1;
        if (step_q == 3'd1) begin
          norm_d = ProdW'(prod);
        end else if (step_q != '0) begin
          norm_d = norm_q + ProdW'(prod);
        end
        if (mag_over) res_d = it_q[ResW-1:0];
      end
      ST_CMP: begin
        if (norm_over) begin
          res_d = it_q[ResW-1:0];
        end else begin
          for (int n = 0; n < 4; n++) q_d[n] = nq_q[n][DataW-1:0];
          it_d = it_q + 16'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      it_q    <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      it_q    <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q      <= q_d;
    nq_q     <= nq_d;
    norm_q   <= norm_d;
    rad_sq_q <= rad_sq_d;
    res_q    <= res_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      const_real_q <= ConstRealRst;
      const_i_q    <= ConstIRst;
      const_j_q    <= ConstJRst;
      const_k_q    <= ConstKRst;
      max_iter_q   <= MaxIterRst;
      radius_q     <= RadiusRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CONST_REAL: const_real_q <= cfg_wdata_i;
        CFG_CONST_I:    const_i_q    <= cfg_wdata_i;
        CFG_CONST_J:    const_j_q    <= cfg_wdata_i;
        CFG_CONST_K:    const_k_q    <= cfg_wdata_i;
        CFG_MAX_ITER:   max_iter_q   <= cfg_wdata_i[IterW-1:0];
        CFG_RADIUS:     radius_q     <= cfg_wdata_i[RadW-1:0];
        default: ;
      endcase
    end
  end

  assign busy_o         = state_q != ST_IDLE;
  assign done_o         = state_q == ST_DONE;
  assign escape_count_o = IterW'(res_q);

  // a result beat is always followed by a free cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !busy_o)
    else $error("busy after result beat");

  // an accepted start occupies the unit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("start beat not taken");

  // the iteration counter never runs past the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (it_q <= max_iter_q))
    else $error("iteration counter beyond max_iter");

  // the norm pass ends at its last step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NORM) |-> (step_q <= NormLastStep))
    else $error("norm step out of range");

endmodule
